/* sv/spq_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_core.
package spq_pkg;

    localparam int DEF_QUEUE_DEPTH  = 10;
    localparam int DEF_PAYLOAD_BITS = 32;

    localparam int LEVEL_W  = 3;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 4;

    localparam logic [LEVEL_W-1:0] SENTINEL_LEVEL = 3'd6;
    localparam logic [LEVEL_W-1:0] TOP_LEVEL      = 3'd1;
    localparam logic [LEVEL_W-1:0] BOTTOM_LEVEL   = 3'd5;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic               enq;
        logic               deq;
        logic [LEVEL_W-1:0] level;
    } spq_cmd_t;

endpackage

/* sv/spq_cell.sv */
`timescale 1ns / 1ps
// One slot of the sorted queue: holds a level and payload, compares against
// the broadcast level and shifts toward either neighbor. Depends on spq_pkg.
module spq_cell #(
    parameter int PAYLOAD_BITS = spq_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spq_pkg::spq_cmd_t             cmd,
    input  logic [PAYLOAD_BITS-1:0]       new_payload,
    input  logic                          left_le,
    input  logic [spq_pkg::LEVEL_W-1:0]   left_level,
    input  logic [PAYLOAD_BITS-1:0]       left_payload,
    input  logic [spq_pkg::LEVEL_W-1:0]   right_level,
    input  logic [PAYLOAD_BITS-1:0]       right_payload,
    output logic                          le,
    output logic [spq_pkg::LEVEL_W-1:0]   level,
    output logic [PAYLOAD_BITS-1:0]       payload
);
    import spq_pkg::*;

    logic [LEVEL_W-1:0]      level_reg;
    logic [LEVEL_W-1:0]      level_next;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [PAYLOAD_BITS-1:0] payload_next;

    // Sentinel never compares at or below a real level, so empty slots move
    assign le = (level_reg <= cmd.level);

    always_comb
    begin
        level_next   = level_reg;
        payload_next = payload_reg;
        if (cmd.deq)
        begin
            level_next   = right_level;
            payload_next = right_payload;
        end
        else if (cmd.enq && !le)
        begin
            if (left_le)
            begin
                level_next   = cmd.level;
                payload_next = new_payload;
            end
            else
            begin
                level_next   = left_level;
                payload_next = left_payload;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= SENTINEL_LEVEL;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
    end

    assign level   = level_reg;
    assign payload = payload_reg;

endmodule

/* sv/sorted_priority_queue_core.sv */
`timescale 1ns / 1ps
// Top level of the sorted priority queue: command decode, row of spq_cell
// slots, fill counter and output register. Depends on spq_pkg and spq_cell.
//
//  Channel   Dir  Handshake          Contents
//  s_axis    in   s_tvalid/s_tready  opcode, in_level, in_payload
//  m_axis    out  m_tvalid/m_tready  status, out_level, out_payload, fill_count
//
// Throughput: one beat per clock unless stalled. Every slot compares the new level
// against its own and shifts in the same cycle, so the compare-and-shift across
// the cell row sets the rate; the result is then registered in the output register.
// Reset: all slots return to the sentinel level and the count to zero at
// once; there is no clearing pass. Stalls: s_tready drops only while a result
// is held in the output register and m_tready is low.
module sorted_priority_queue_core #(
    parameter int  QUEUE_DEPTH  = spq_pkg::DEF_QUEUE_DEPTH,
    parameter int  PAYLOAD_BITS = spq_pkg::DEF_PAYLOAD_BITS,
    localparam int IN_W  = ((1 + spq_pkg::LEVEL_W + PAYLOAD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((spq_pkg::STATUS_W + spq_pkg::LEVEL_W + PAYLOAD_BITS
                             + spq_pkg::FILL_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // opcode, in_level, in_payload, zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, out_level, out_payload, fill_count, pad
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_USED = STATUS_W + LEVEL_W + PAYLOAD_BITS + FILL_W;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Input beat fields
    logic                    in_op;
    logic [LEVEL_W-1:0]      in_level_raw;
    logic [LEVEL_W-1:0]      in_level_sat;
    logic [PAYLOAD_BITS-1:0] in_payload;

    assign in_op        = s_tdata[0];
    assign in_level_raw = s_tdata[LEVEL_W:1];
    assign in_payload   = s_tdata[1 + LEVEL_W +: PAYLOAD_BITS];

    // Clamp out-of-range levels into the legal band
    always_comb
    begin
        if (in_level_raw < TOP_LEVEL)
            in_level_sat = TOP_LEVEL;
        else if (in_level_raw > BOTTOM_LEVEL)
            in_level_sat = BOTTOM_LEVEL;
        else
            in_level_sat = in_level_raw;
    end

    logic             accept;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             full;
    logic             empty;
    logic             do_enq;
    logic             do_deq;
    spq_cmd_t         cmd;

    assign accept = s_tvalid && s_tready;
    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_enq = accept && (in_op == OP_ENQUEUE) && !full;
    assign do_deq = accept && (in_op == OP_DEQUEUE) && !empty;

    assign cmd.enq   = do_enq;
    assign cmd.deq   = do_deq;
    assign cmd.level = in_level_sat;

    // Cell row: slot 0 is the head
    logic [LEVEL_W-1:0]      cell_level   [QUEUE_DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_payload [QUEUE_DEPTH];
    logic                    cell_le      [QUEUE_DEPTH];

    for (genvar k = 0; k < QUEUE_DEPTH; k++)
    begin : g_cell
        logic                    left_le;
        logic [LEVEL_W-1:0]      left_level;
        logic [PAYLOAD_BITS-1:0] left_payload;
        logic [LEVEL_W-1:0]      right_level;
        logic [PAYLOAD_BITS-1:0] right_payload;

        if (k == 0)
        begin : g_head
            // Nothing ahead of the head: a new entry that loses to no slot lands here
            assign left_le      = 1'b1;
            assign left_level   = SENTINEL_LEVEL;
            assign left_payload = '0;
        end
        else
        begin : g_body
            assign left_le      = cell_le[k-1];
            assign left_level   = cell_level[k-1];
            assign left_payload = cell_payload[k-1];
        end

        if (k == QUEUE_DEPTH - 1)
        begin : g_tail
            // Refill the freed tail with the sentinel on dequeue
            assign right_level   = SENTINEL_LEVEL;
            assign right_payload = '0;
        end
        else
        begin : g_inner
            assign right_level   = cell_level[k+1];
            assign right_payload = cell_payload[k+1];
        end

        spq_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cmd           (cmd),
            .new_payload   (in_payload),
            .left_le       (left_le),
            .left_level    (left_level),
            .left_payload  (left_payload),
            .right_level   (right_level),
            .right_payload (right_payload),
            .le            (cell_le[k]),
            .level         (cell_level[k]),
            .payload       (cell_payload[k])
        );
    end

    // Fill counter
    always_comb
    begin
        count_next = count_reg;
        if (do_enq)
            count_next = count_reg + CNT_W'(1);
        else if (do_deq)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Result of the beat being accepted
    status_t                 res_status;
    logic [LEVEL_W-1:0]      res_level;
    logic [PAYLOAD_BITS-1:0] res_payload;

    always_comb
    begin
        res_status  = STATUS_DONE;
        res_level   = '0;
        res_payload = '0;
        if (in_op == OP_ENQUEUE)
        begin
            if (full)
                res_status = STATUS_FULL;
        end
        else
        begin
            if (empty)
            begin
                res_status = STATUS_EMPTY;
            end
            else
            begin
                res_level   = cell_level[0];
                res_payload = cell_payload[0];
            end
        end
    end

    // Output register: hold the result until the master side takes it
    logic                    out_valid_reg;
    logic                    out_valid_next;
    status_t                 out_status_reg;
    logic [LEVEL_W-1:0]      out_level_reg;
    logic [PAYLOAD_BITS-1:0] out_payload_reg;
    logic [FILL_W-1:0]       out_fill_reg;

    assign s_tready = !out_valid_reg || m_tready;

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_status_reg  <= res_status;
            out_level_reg   <= res_level;
            out_payload_reg <= res_payload;
            out_fill_reg    <= FILL_W'(count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - OUT_USED){1'b0}}, out_fill_reg, out_payload_reg,
                       out_level_reg, out_status_reg};

endmodule

/* bench/spq_tb_pkg.sv */
`timescale 1ns / 1ps
// Operation and status codes plus the result record shared by the bench files.
// Depends on spq_pkg for the field widths.
package spq_tb_pkg;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } spq_op_e;

    typedef enum logic [spq_pkg::STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } spq_status_e;

    typedef struct packed {
        logic [spq_pkg::STATUS_W-1:0] status;
        logic [spq_pkg::LEVEL_W-1:0]  level;
        logic [31:0]                  payload;
        logic [spq_pkg::FILL_W-1:0]   fill;
    } spq_result_t;

endpackage

/* bench/spq_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for sorted_priority_queue_core: keeps a shadow copy of the queue,
// predicts each result beat and compares it. Depends on spq_pkg, spq_tb_pkg.
module spq_checker #(
    parameter int QUEUE_DEPTH  = 10,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    import spq_pkg::*;
    import spq_tb_pkg::*;

    logic [LEVEL_W-1:0]      shadow_level [QUEUE_DEPTH];
    logic [PAYLOAD_BITS-1:0] shadow_payload [QUEUE_DEPTH];
    int                      shadow_count;
    spq_result_t             awaited_results [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // Apply one beat to the shadow queue and return the result it should give.
    function automatic spq_result_t queue_step(input logic [39:0] beat);
        spq_result_t             res;
        logic [LEVEL_W-1:0]      lvl;
        logic [PAYLOAD_BITS-1:0] pay;
        int                      pos;
        res = '0;
        lvl = beat[3:1];
        pay = beat[35:4];
        if (beat[0] == OP_ENQUEUE) begin
            if (shadow_count >= QUEUE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                if (lvl < TOP_LEVEL) lvl = TOP_LEVEL;
                if (lvl > BOTTOM_LEVEL) lvl = BOTTOM_LEVEL;
                pos = 0;
                for (int k = 0; k < shadow_count; k++)
                    if (shadow_level[k] <= lvl) pos++;
                for (int k = shadow_count; k > pos; k--) begin
                    shadow_level[k]   = shadow_level[k-1];
                    shadow_payload[k] = shadow_payload[k-1];
                end
                shadow_level[pos]   = lvl;
                shadow_payload[pos] = pay;
                shadow_count++;
                res.status = ST_DONE;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.status  = ST_DONE;
                res.level   = shadow_level[0];
                res.payload = shadow_payload[0];
                for (int k = 0; k + 1 < shadow_count; k++) begin
                    shadow_level[k]   = shadow_level[k+1];
                    shadow_payload[k] = shadow_payload[k+1];
                end
                shadow_count--;
                shadow_level[shadow_count]   = SENTINEL_LEVEL;
                shadow_payload[shadow_count] = '0;
            end
        end
        res.fill = shadow_count[FILL_W-1:0];
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        spq_result_t want;
        if (!rst_n) begin
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
                shadow_level[k]   = SENTINEL_LEVEL;
                shadow_payload[k] = '0;
            end
            shadow_count = 0;
            awaited_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result beat %0h with no expectation waiting", m_tdata);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("status", want.status, m_tdata[1:0]);
                    compare_field("out_level", want.level, m_tdata[4:2]);
                    compare_field("out_payload", want.payload, m_tdata[36:5]);
                    compare_field("fill_count", want.fill, m_tdata[40:37]);
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(queue_step(s_tdata));
        end
        pending = awaited_results.size();
    end

endmodule

/* bench/sorted_priority_queue_core_tb.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for sorted_priority_queue_core; checking is done by
// spq_checker. Depends on spq_pkg, spq_tb_pkg, spq_checker and the RTL.
module sorted_priority_queue_core_tb;
    import spq_tb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // opcode, in_level, in_payload, zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // status, out_level, out_payload, fill_count, pad

    int fail_count;
    int pending;
    int cycles = 0;
    int send_idle_pct = 0;        // chance that the sender holds off a cycle
    int recv_stall_pct = 0;       // chance that the receiver drops m_tready

    always #1 clk = ~clk;

    sorted_priority_queue_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    spq_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: stall at random with the current phase's rate; stay low in reset.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: give up on a hung or lost handshake.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("sorted_priority_queue_core test failed");
            $finish;
        end
    end

    // Drive one input beat and hold it until the edge that accepts it. Idle
    // cycles go in front of the beat, so s_tvalid is only ever assigned once
    // per edge.
    task automatic send_beat(input spq_op_e op, input logic [2:0] level,
                             input logic [31:0] payload);
        logic [39:0] beat;
        beat = '0;
        beat[0] = op;
        beat[3:1] = level;
        beat[35:4] = payload;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge clk); while (!s_tready);
    endtask

    // Random traffic in bursts with a changing enqueue bias, so the queue
    // swings between empty and full and both refusals keep occurring.
    task automatic random_traffic(input int count);
        int enq_pct;
        logic [2:0] level;
        for (int n = 0; n < count; n++) begin
            if (n % 20 == 0)
                enq_pct = 25 + 25 * $urandom_range(2);
            // mostly legal levels; now and then the saturating ones
            if ($urandom_range(99) < 85)
                level = 3'($urandom_range(5, 1));
            else
                level = 3'($urandom_range(7));
            send_beat(($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE,
                      level, $urandom);
        end
    endtask

    initial begin
        logic [2:0]  fill_levels [10];
        logic [31:0] fill_payloads [10];

        fill_levels   = '{3'd0, 3'd7, 3'd3, 3'd1, 3'd5, 3'd6, 3'd3, 3'd2, 3'd4, 3'd3};
        fill_payloads = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                          32'h8000_0001, 32'h7FFF_FFFE, 32'h1234_5678, 32'hDEAD_BEEF,
                          32'h0F0F_0F0F, 32'hF0F0_F0F0};

        // Hold reset, then release it once.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: dequeue while empty, fill to the top with every level
        // (0 and 6/7 saturate; equal levels must leave in arrival order),
        // refuse an enqueue while full, then drain past empty.
        send_beat(OP_DEQUEUE, 3'd0, 32'h0);
        for (int k = 0; k < 10; k++)
            send_beat(OP_ENQUEUE, fill_levels[k], fill_payloads[k]);
        send_beat(OP_ENQUEUE, 3'd1, 32'hCAFE_F00D);
        for (int k = 0; k < 11; k++)
            send_beat(OP_DEQUEUE, 3'd7, 32'hFFFF_FFFF);

        // Random phases: none, sender idle, receiver stall, both.
        random_traffic(RANDOM_ITEMS / 4);
        send_idle_pct = 76;
        recv_stall_pct = 0;
        random_traffic(RANDOM_ITEMS / 4);
        send_idle_pct = 0;
        recv_stall_pct = 76;
        random_traffic(RANDOM_ITEMS / 4);
        send_idle_pct = 28;
        recv_stall_pct = 28;
        random_traffic(RANDOM_ITEMS / 4);

        // Drop valid, let the receiver take everything and drain the pipeline.
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("sorted_priority_queue_core test passed");
        else
            $display("sorted_priority_queue_core test failed");
        $finish;
    end

endmodule

/* files.f */
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue_core.sv
bench/spq_tb_pkg.sv
bench/spq_checker.sv
bench/sorted_priority_queue_core_tb.sv
